>>> design/layered_step_sequencer_top_macros.svh
// Assertion macros for the layered step sequencer.
`ifndef LAYERED_STEP_SEQUENCER_TOP_MACROS_SVH
`define LAYERED_STEP_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LSS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LSS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define LSS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define LSS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> design/lss_pkg.sv
// Package with types and constants of the layered step sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lss_pkg;
    localparam int MAX_LAYERS = 8;
    localparam int MAX_STEPS = 16;
    localparam int SPEED_FRAC_BITS = 12;

    localparam logic [2:0] K_TICK = 3'd0;
    localparam logic [2:0] K_HDR = 3'd1;
    localparam logic [2:0] K_DUR = 3'd2;
    localparam logic [2:0] K_PLAY = 3'd3;
    localparam logic [2:0] K_STOP = 3'd4;
    localparam logic [1:0] CFG_LAYER_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOOP = 2'd1;
    localparam logic [1:0] CFG_INV_SPEED = 2'd2;
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_RUN = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_ms;
        logic [2:0]  layer_sel;
        logic [3:0]  step_sel;
        logic [15:0] step_duration_ms;
        logic [4:0]  step_total_in;
        logic [7:0]  group_tag_in;
        logic [7:0]  after_tag_in;
        logic        async_in;
    } t_in;

    typedef struct packed {
        logic        is_fire;
        logic [2:0]  fire_layer;
        logic [3:0]  fire_step;
        logic [15:0] fire_duration_ms;
        logic        playing_now;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARM,
        S_ARMF,
        S_TK_RD,
        S_TK_EV,
        S_PR_I,
        S_PR_J,
        S_BAR,
        S_FIRE_RD,
        S_FIRE_MUL,
        S_FIRE_OUT,
        S_STAT
    } t_state;

    typedef enum logic [1:0] {
        R_ARMF,
        R_TICK,
        R_PROM
    } t_ret;
endpackage
`default_nettype wire

>>> design/lss_if.sv
// Valid/ready channel interfaces of the layered step sequencer.
`timescale 1ns / 1ps
`default_nettype none
interface lss_in_if import lss_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lss_out_if import lss_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lss_cfg_if import lss_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/lss_ram.sv
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> design/lss_scale.sv
// Shared multiply unit: scales a step duration by the clamped inverse speed.
`timescale 1ns / 1ps
`default_nettype none
module lss_scale #(
    parameter int FRAC = 12
) (
    input  wire logic        i_clk,
    input  wire logic [15:0] i_dur,
    input  wire logic [15:0] i_inv,
    output logic      [31:0] o_scaled
);
    localparam int ONE = 1 << FRAC;
    localparam logic [19:0] INV_MIN = 20'(ONE / 10);
    localparam logic [19:0] INV_MAX = 20'(ONE * 10);
    logic [19:0] inv_c;
    logic [35:0] prod;
    always_comb begin
        inv_c = {4'd0, i_inv};
        if (inv_c < INV_MIN) inv_c = INV_MIN;
        if (inv_c > INV_MAX) inv_c = INV_MAX;
        prod = {20'd0, i_dur} * {16'd0, inv_c};
    end
    always_ff @(posedge i_clk) begin
        o_scaled <= 32'(prod >> FRAC);
    end
endmodule
`default_nettype wire

>>> design/layered_step_sequencer_top.sv
// Layered step sequencer: per-layer state walk with one shared scaler.
// Each item ends in a status result; writes, stop and stopped ticks give only the status.
// Play arms the layers and fires each running one; a tick walks the running layers, then
// promotes waiting layers by tag, with a fire per step advance or promotion; a loop restart re-arms.
// Throughput: one item at a time, the next one taken after the status is registered; stalls hold it.
// Reset (synchronous, active low): stopped, all layers waiting, registers default.
`timescale 1ns / 1ps
`default_nettype none
`include "layered_step_sequencer_top_macros.svh"
module layered_step_sequencer_top import lss_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    lss_in_if.sink   in_ch,
    lss_out_if.source out_ch,
    lss_cfg_if.sink  cfg_ch
);
    localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int AW = LW + SW;
    localparam int DEPTH = MAX_LAYERS * MAX_STEPS;
    localparam int CW = LW + 1;
    localparam int TW = $clog2(MAX_STEPS + 1);

    t_state r_st, n_st;
    t_ret   r_ret, n_ret;
    t_in    r_it;
    logic [3:0]  r_lcount;
    logic        r_loop;
    logic [15:0] r_inv;
    logic        r_running, n_running;
    logic [1:0]  r_ph [MAX_LAYERS];
    logic [SW-1:0] r_si [MAX_LAYERS];
    logic [31:0] r_t0 [MAX_LAYERS];
    logic [TW-1:0] r_tot [MAX_LAYERS];
    logic [7:0]  r_gt [MAX_LAYERS];
    logic [7:0]  r_at [MAX_LAYERS];
    logic        r_as [MAX_LAYERS];
    logic [CW-1:0] r_i, r_j;
    logic        r_ov;
    t_out        r_od;
    logic        r_ready_in;
    logic        r_tk_w;

    logic [CW-1:0] nused;
    logic [LW-1:0] li, lj;
    logic          acc_in, acc_out, ram_we, out_load;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [15:0]   ram_q;
    logic [31:0]   sc;
    logic [31:0]   elapsed;
    logic          all_sync_done, any_sync, any_async;
    logic [TW-1:0] tot_in;
    t_state        tk_next, pr_next;

    assign nused = (r_lcount > 4'(MAX_LAYERS)) ? CW'(MAX_LAYERS) : CW'(r_lcount);
    assign li = r_i[LW-1:0];
    assign lj = r_j[LW-1:0];
    assign acc_in = in_ch.valid && in_ch.ready;
    assign acc_out = out_ch.valid && out_ch.ready;
    assign out_load = (r_st == S_FIRE_OUT || r_st == S_STAT) && (!r_ov || acc_out);
    assign in_ch.ready = r_ready_in;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ov;
    assign out_ch.data = r_od;
    assign elapsed = r_it.now_ms - r_t0[li];

    assign ram_we = (r_st == S_IDLE) && acc_in && in_ch.data.kind == K_DUR
        && 32'(in_ch.data.layer_sel) < MAX_LAYERS && 32'(in_ch.data.step_sel) < MAX_STEPS;
    assign ram_wa = AW'(32'(in_ch.data.layer_sel) * MAX_STEPS + 32'(in_ch.data.step_sel));
    assign ram_ra = AW'(32'(li) * MAX_STEPS + 32'(r_si[li]));
    assign tot_in = (32'(in_ch.data.step_total_in) > MAX_STEPS)
        ? TW'(MAX_STEPS) : TW'(in_ch.data.step_total_in);

    lss_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(in_ch.data.step_duration_ms),
        .i_raddr(ram_ra), .o_rdata(ram_q)
    );
    lss_scale #(.FRAC(SPEED_FRAC_BITS)) u_scale (
        .i_clk(i_clk), .i_dur(ram_q), .i_inv(r_inv), .o_scaled(sc)
    );

    always_comb begin
        all_sync_done = 1'b1;
        any_sync = 1'b0;
        any_async = 1'b0;
        for (int k = 0; k < MAX_LAYERS; k++) begin
            if (k < 32'(nused)) begin
                if (r_as[k]) any_async = 1'b1;
                else begin
                    any_sync = 1'b1;
                    if (r_ph[k] != PH_DONE) all_sync_done = 1'b0;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        n_ret = r_ret;
        n_running = r_running;
        unique case (r_st)
            S_IDLE: if (acc_in) begin
                unique case (in_ch.data.kind)
                    K_TICK: n_st = r_running ? S_TK_RD : S_STAT;
                    K_PLAY: begin n_st = S_ARM; n_running = 1'b1; end
                    K_STOP: begin n_st = S_STAT; n_running = 1'b0; end
                    default: n_st = S_STAT;
                endcase
            end
            S_ARM: if (r_i + 1'b1 >= nused) n_st = S_ARMF;
            S_ARMF: begin
                n_ret = R_ARMF;
                if (r_i >= nused) n_st = S_STAT;
                else if (r_ph[li] == PH_RUN && (r_it.kind == K_PLAY || !r_as[li]))
                    n_st = S_FIRE_RD;
            end
            S_TK_RD: begin
                n_ret = R_TICK;
                if (r_i >= nused) n_st = S_PR_I;
                else if (r_ph[li] == PH_RUN) n_st = S_TK_EV;
            end
            S_TK_EV: n_st = tk_next;
            S_PR_I: begin
                n_ret = R_PROM;
                if (r_i >= nused) n_st = S_BAR;
                else if (r_ph[li] == PH_WAIT) n_st = S_PR_J;
            end
            S_PR_J: n_st = pr_next;
            S_BAR: begin
                n_st = S_STAT;
                if (any_sync && all_sync_done) begin
                    if (r_loop) n_st = S_ARM;
                    else if (!any_async) n_running = 1'b0;
                end
            end
            S_FIRE_RD: n_st = S_FIRE_MUL;
            S_FIRE_MUL: n_st = S_FIRE_OUT;
            S_FIRE_OUT: if (!r_ov || acc_out) begin
                unique case (r_ret)
                    R_ARMF: n_st = S_ARMF;
                    R_TICK: n_st = S_TK_RD;
                    default: n_st = S_PR_I;
                endcase
            end
            S_STAT: if (!r_ov || acc_out) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // decisions for multi-cycle states
    always_comb begin
        tk_next = S_TK_RD;
        if (r_tk_w) begin
            if (ram_q == 16'd0 || 33'(elapsed) < 33'(sc)) tk_next = S_TK_RD;
            else if (32'(r_si[li]) + 1 < 32'(r_tot[li]) || r_as[li]) tk_next = S_FIRE_RD;
            else tk_next = S_TK_RD;
        end else tk_next = S_TK_EV;
        pr_next = S_PR_J;
        if (r_j >= nused || r_gt[lj] == r_at[li]) begin
            if (r_j >= nused || r_ph[lj] == PH_DONE) pr_next = S_FIRE_RD;
            else pr_next = S_PR_I;
        end
    end

    // outputs and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ret <= R_ARMF;
            r_running <= 1'b0;
            r_ov <= 1'b0;
            r_ready_in <= 1'b0;
            r_lcount <= 4'd0;
            r_loop <= 1'b0;
            r_inv <= 16'd4096;
            r_tk_w <= 1'b0;
            for (int k = 0; k < MAX_LAYERS; k++) begin
                r_ph[k] <= PH_WAIT;
                r_si[k] <= '0;
                r_t0[k] <= '0;
            end
        end else begin
            r_st <= n_st;
            r_ret <= n_ret;
            r_running <= n_running;
            r_ready_in <= (n_st == S_IDLE) && !(r_st == S_IDLE && acc_in);
            if (out_load) r_ov <= 1'b1;
            else if (acc_out) r_ov <= 1'b0;
            if (cfg_ch.valid) begin
                unique case (cfg_ch.data.index)
                    CFG_LAYER_COUNT: r_lcount <= cfg_ch.data.data[3:0];
                    CFG_LOOP: r_loop <= cfg_ch.data.data[0];
                    CFG_INV_SPEED: r_inv <= cfg_ch.data.data;
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: begin
                    r_i <= '0;
                    if (acc_in) begin
                        r_it <= in_ch.data;
                        if (in_ch.data.kind == K_HDR && 32'(in_ch.data.layer_sel) < MAX_LAYERS)
                        begin
                            r_tot[LW'(in_ch.data.layer_sel)] <= tot_in;
                            r_gt[LW'(in_ch.data.layer_sel)] <= in_ch.data.group_tag_in;
                            r_at[LW'(in_ch.data.layer_sel)] <= in_ch.data.after_tag_in;
                            r_as[LW'(in_ch.data.layer_sel)] <= in_ch.data.async_in;
                        end
                        if (in_ch.data.kind == K_PLAY || in_ch.data.kind == K_STOP) begin
                            for (int k = 0; k < MAX_LAYERS; k++) r_ph[k] <= PH_WAIT;
                        end
                    end
                end
                S_ARM: begin
                    if (r_i < nused && (r_it.kind == K_PLAY || !r_as[li])) begin
                        r_si[li] <= '0;
                        r_t0[li] <= r_it.now_ms;
                        if (r_tot[li] == '0) r_ph[li] <= PH_DONE;
                        else if (r_at[li] == 8'd0) r_ph[li] <= PH_RUN;
                        else r_ph[li] <= PH_WAIT;
                    end
                    r_i <= (r_i + 1'b1 >= nused) ? '0 : r_i + 1'b1;
                end
                S_ARMF: if (n_st != S_FIRE_RD) r_i <= r_i + 1'b1;
                S_TK_RD: begin
                    r_tk_w <= 1'b0;
                    if (r_i >= nused) r_i <= '0;
                    else if (r_ph[li] != PH_RUN) r_i <= r_i + 1'b1;
                end
                S_TK_EV: begin
                    r_tk_w <= !r_tk_w;
                    if (r_tk_w) begin
                        if (tk_next == S_FIRE_RD) begin
                            r_t0[li] <= r_it.now_ms;
                            if (32'(r_si[li]) + 1 < 32'(r_tot[li])) r_si[li] <= r_si[li] + 1'b1;
                            else r_si[li] <= '0;
                        end else begin
                            if (ram_q != 16'd0 && 33'(elapsed) >= 33'(sc))
                                r_ph[li] <= PH_DONE;
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_PR_I: begin
                    r_j <= '0;
                    if (r_i >= nused) r_i <= '0;
                    else if (r_ph[li] != PH_WAIT) r_i <= r_i + 1'b1;
                end
                S_PR_J: begin
                    if (pr_next == S_FIRE_RD) begin
                        r_ph[li] <= PH_RUN;
                        r_si[li] <= '0;
                        r_t0[li] <= r_it.now_ms;
                    end else if (pr_next == S_PR_I) r_i <= r_i + 1'b1;
                    else r_j <= r_j + 1'b1;
                end
                S_BAR: r_i <= '0;
                S_FIRE_OUT: if (out_load) begin
                    r_od.is_fire <= 1'b1;
                    r_od.fire_layer <= 3'(li);
                    r_od.fire_step <= 4'(r_si[li]);
                    r_od.fire_duration_ms <= (ram_q == 16'd0) ? 16'd0
                        : ((sc > 32'd65535) ? 16'hFFFF : sc[15:0]);
                    r_od.playing_now <= r_running;
                    r_od.last <= 1'b0;
                    r_i <= r_i + 1'b1;
                end
                S_STAT: if (out_load) begin
                    r_od <= '{is_fire: 1'b0, fire_layer: 3'd0, fire_step: 4'd0,
                              fire_duration_ms: 16'd0, playing_now: r_running, last: 1'b1};
                end
                default: ;
            endcase
        end
    end

    `LSS_ASSERT_NEXT(a_no_overwrite, i_clk, i_rst_n, r_ov && !out_ch.ready, r_ov, "result lost")
    `LSS_ASSERT_IMPL(a_busy, i_clk, i_rst_n, !(in_ch.ready && r_st != S_IDLE), "ready while busy")
    `LSS_ASSERT_NEXT(a_stat, i_clk, i_rst_n, r_st == S_STAT && !r_ov, r_ov && r_od.last, "no status")
endmodule
`default_nettype wire

>>> bench/lss_sequencer_checker.sv
// Checker that predicts the sequencer's fire and status results and compares them.
`timescale 1ns / 1ps
module lss_sequencer_checker import lss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lss_in_if    in_ch,
    lss_out_if   out_ch,
    lss_cfg_if   cfg_ch,
    output int   o_pending,
    output int   o_fail_count
);
    localparam int NL = 8;
    localparam int NS = 16;

    logic [3:0]  layer_count_r;
    logic        loop_r;
    logic [15:0] inv_speed_r;
    logic [1:0]  phase_m [NL];
    logic [3:0]  step_m [NL];
    logic [31:0] start_m [NL];
    logic [15:0] dur_m [NL*NS];
    logic [4:0]  total_m [NL];
    logic [7:0]  group_m [NL];
    logic [7:0]  after_m [NL];
    logic        async_m [NL];
    logic        playing;

    t_out expected_results[$];
    t_out item_results[$];
    int   fails;

    function automatic int used_layers();
        return (layer_count_r > NL) ? NL : int'(layer_count_r);
    endfunction

    function automatic logic [31:0] scale_ms(logic [15:0] d);
        logic [31:0] inv;
        inv = {16'd0, inv_speed_r};
        if (inv < 32'd409) inv = 32'd409;
        if (inv > 32'd40960) inv = 32'd40960;
        return ({16'd0, d} * inv) >> 12;
    endfunction

    task automatic add_fire(int i);
        t_out r;
        logic [31:0] e;
        e = 32'd0;
        if (dur_m[i*NS + step_m[i]] != 16'd0) begin
            e = scale_ms(dur_m[i*NS + step_m[i]]);
            if (e > 32'd65535) e = 32'd65535;
        end
        r = '0;
        r.is_fire          = 1'b1;
        r.fire_layer       = 3'(i);
        r.fire_step        = step_m[i];
        r.fire_duration_ms = e[15:0];
        item_results.push_back(r);
    endtask

    task automatic arm_layers(logic [31:0] now, bit with_async);
        int n;
        n = used_layers();
        for (int i = 0; i < n; i++) begin
            if (!with_async && async_m[i]) continue;
            step_m[i]  = 4'd0;
            start_m[i] = now;
            if (total_m[i] == 5'd0) phase_m[i] = PH_DONE;
            else if (after_m[i] == 8'd0) phase_m[i] = PH_RUN;
            else phase_m[i] = PH_WAIT;
        end
        for (int i = 0; i < n; i++) begin
            if (!with_async && async_m[i]) continue;
            if (phase_m[i] == PH_RUN) add_fire(i);
        end
    endtask

    task automatic tick_layers(logic [31:0] now);
        int n;
        logic [15:0] d;
        logic [4:0] nxt;
        bit ok;
        bit any_sync;
        bit any_async;
        bit all_done;
        n = used_layers();
        any_sync = 0;
        any_async = 0;
        all_done = 1;
        if (!playing) return;
        for (int i = 0; i < n; i++) begin
            if (phase_m[i] != PH_RUN) continue;
            d = dur_m[i*NS + step_m[i]];
            if (d == 16'd0) continue;
            if ((now - start_m[i]) < scale_ms(d)) continue;
            nxt = {1'b0, step_m[i]} + 5'd1;
            if (nxt < total_m[i]) begin
                step_m[i]  = nxt[3:0];
                start_m[i] = now;
                add_fire(i);
            end else if (async_m[i]) begin
                step_m[i]  = 4'd0;
                start_m[i] = now;
                add_fire(i);
            end else begin
                phase_m[i] = PH_DONE;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (phase_m[i] != PH_WAIT) continue;
            ok = 1;
            for (int j = 0; j < n; j++) begin
                if (group_m[j] == after_m[i]) begin
                    ok = (phase_m[j] == PH_DONE);
                    break;
                end
            end
            if (!ok) continue;
            phase_m[i] = PH_RUN;
            step_m[i]  = 4'd0;
            start_m[i] = now;
            add_fire(i);
        end
        for (int i = 0; i < n; i++) begin
            if (async_m[i]) begin
                any_async = 1;
                continue;
            end
            any_sync = 1;
            if (phase_m[i] != PH_DONE) all_done = 0;
        end
        if (!all_done || !any_sync) return;
        if (loop_r) arm_layers(now, 0);
        else if (!any_async) playing = 0;
    endtask

    task automatic predict_item(t_in it);
        t_out st;
        item_results.delete();
        case (it.kind)
            K_TICK: tick_layers(it.now_ms);
            K_HDR: begin
                total_m[it.layer_sel] = (it.step_total_in > 5'd16) ? 5'd16 : it.step_total_in;
                group_m[it.layer_sel] = it.group_tag_in;
                after_m[it.layer_sel] = it.after_tag_in;
                async_m[it.layer_sel] = it.async_in;
            end
            K_DUR: dur_m[it.layer_sel*NS + it.step_sel] = it.step_duration_ms;
            K_PLAY: begin
                foreach (phase_m[i]) phase_m[i] = PH_WAIT;
                playing = 1;
                arm_layers(it.now_ms, 1);
            end
            K_STOP: begin
                playing = 0;
                foreach (phase_m[i]) phase_m[i] = PH_WAIT;
            end
            default: ;
        endcase
        st = '0;
        st.last = 1'b1;
        item_results.push_back(st);
        foreach (item_results[k]) begin
            item_results[k].playing_now = playing;
            expected_results.push_back(item_results[k]);
        end
    endtask

    always @(posedge i_clk) begin
        t_out e;
        t_out a;
        if (!i_rst_n) begin
            layer_count_r = 4'd0;
            loop_r        = 1'b0;
            inv_speed_r   = 16'd4096;
            playing       = 1'b0;
            foreach (phase_m[i]) begin
                phase_m[i] = PH_WAIT;
                step_m[i]  = 4'd0;
                start_m[i] = 32'd0;
            end
            expected_results.delete();
            fails = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.data.index)
                    CFG_LAYER_COUNT: layer_count_r = cfg_ch.data.data[3:0];
                    CFG_LOOP:        loop_r = cfg_ch.data.data[0];
                    CFG_INV_SPEED:   inv_speed_r = cfg_ch.data.data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                a = out_ch.data;
                if (expected_results.size() == 0) begin
                    $error("unexpected result %p", a);
                    fails++;
                end else begin
                    e = expected_results.pop_front();
                    if (a.is_fire !== e.is_fire) begin
                        $error("is_fire exp %0d got %0d", e.is_fire, a.is_fire);
                        fails++;
                    end
                    if (a.fire_layer !== e.fire_layer) begin
                        $error("fire_layer exp %0d got %0d", e.fire_layer, a.fire_layer);
                        fails++;
                    end
                    if (a.fire_step !== e.fire_step) begin
                        $error("fire_step exp %0d got %0d", e.fire_step, a.fire_step);
                        fails++;
                    end
                    if (a.fire_duration_ms !== e.fire_duration_ms) begin
                        $error("fire_duration_ms exp %0d got %0d",
                               e.fire_duration_ms, a.fire_duration_ms);
                        fails++;
                    end
                    if (a.playing_now !== e.playing_now) begin
                        $error("playing_now exp %0d got %0d", e.playing_now, a.playing_now);
                        fails++;
                    end
                    if (a.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, a.last);
                        fails++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) predict_item(in_ch.data);
        end
        o_pending    = expected_results.size();
        o_fail_count = fails;
    end
endmodule

>>> bench/tb_layered_step_sequencer_top.sv
// Stimulus and verdict for the layered step sequencer.
`timescale 1ns / 1ps
module tb_layered_step_sequencer_top;
    import lss_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    int   send_idle;
    int   recv_idle;
    int   pending;
    int   fail_count;
    int   cycles;
    logic [31:0] now_ms;

    lss_in_if  in_ch ();
    lss_out_if out_ch ();
    lss_cfg_if cfg_ch ();

    layered_step_sequencer_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    lss_sequencer_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) out_ch.ready <= ($urandom_range(99) >= recv_idle);

    task automatic send_item(t_in it);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic configure(logic [3:0] lc, logic lp, logic [15:0] inv);
        drain();
        write_reg(CFG_LAYER_COUNT, {12'd0, lc});
        write_reg(CFG_LOOP, {15'd0, lp});
        write_reg(CFG_INV_SPEED, inv);
    endtask

    function automatic t_in noise_item();
        t_in it;
        it.kind             = 3'($urandom_range(7));
        it.now_ms           = $urandom;
        it.layer_sel        = 3'($urandom_range(7));
        it.step_sel         = 4'($urandom_range(15));
        it.step_duration_ms = 16'($urandom);
        it.step_total_in    = 5'($urandom_range(31));
        it.group_tag_in     = 8'($urandom);
        it.after_tag_in     = 8'($urandom);
        it.async_in         = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_in header_item(int layer, int steps, int grp, int aft, bit asy);
        t_in it;
        it = noise_item();
        it.kind          = K_HDR;
        it.layer_sel     = 3'(layer);
        it.step_total_in = 5'(steps);
        it.group_tag_in  = 8'(grp);
        it.after_tag_in  = 8'(aft);
        it.async_in      = asy;
        return it;
    endfunction

    function automatic t_in duration_item(int layer, int step, int d);
        t_in it;
        it = noise_item();
        it.kind             = K_DUR;
        it.layer_sel        = 3'(layer);
        it.step_sel         = 4'(step);
        it.step_duration_ms = 16'(d);
        return it;
    endfunction

    function automatic t_in timed_item(logic [2:0] k, logic [31:0] t);
        t_in it;
        it = noise_item();
        it.kind   = k;
        it.now_ms = t;
        return it;
    endfunction

    function automatic t_in random_item(ref logic [31:0] t);
        int r;
        int d;
        t_in it;
        r = $urandom_range(99);
        if (r < 60) begin
            if ($urandom_range(49) == 0) t = $urandom;
            else t = t + 32'($urandom_range(25));
            it = timed_item(K_TICK, t);
        end else if (r < 68) begin
            it = timed_item(K_PLAY, t);
        end else if (r < 72) begin
            it = timed_item(K_STOP, t);
        end else if (r < 84) begin
            it = header_item($urandom_range(7),
                             ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 5),
                             ($urandom_range(9) == 0) ? $urandom_range(255)
                                                       : $urandom_range(1, 4),
                             $urandom_range(1) ? 0 : $urandom_range(1, 5),
                             $urandom_range(3) == 0);
        end else if (r < 96) begin
            d = $urandom_range(99);
            it = duration_item($urandom_range(7), $urandom_range(15),
                               (d < 10) ? 0 : (d < 18) ? $urandom_range(65535)
                                                       : $urandom_range(1, 12));
        end else begin
            it = noise_item();
            it.kind = 3'($urandom_range(5, 7));
        end
        return it;
    endfunction

    task automatic random_run(int count);
        for (int k = 0; k < count; k++) send_item(random_item(now_ms));
    endtask

    initial begin
        cycles       = 0;
        send_idle    = 0;
        recv_idle    = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        now_ms       = 32'd100;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle = 31;
        recv_idle = 69;
        configure(4'd8, 1'b0, 16'd4096);
        for (int l = 0; l < 8; l++) send_item(header_item(l, 3, l + 1, 0, 0));
        for (int s = 0; s < 128; s++) send_item(duration_item(s / 16, s % 16, 1 + s % 7));

        // directed: stopped tick, unknown kind, dependencies, wrap, extremes
        send_item(timed_item(K_TICK, 32'd0));
        send_item(timed_item(3'd7, 32'hFFFF_FFFF));
        send_item(header_item(1, 2, 2, 1, 0));
        send_item(header_item(2, 2, 3, 9, 0));
        send_item(header_item(3, 0, 4, 0, 0));
        send_item(header_item(4, 31, 255, 0, 1));
        send_item(duration_item(5, 0, 0));
        send_item(duration_item(6, 15, 65535));
        send_item(header_item(6, 16, 6, 0, 0));
        send_item(timed_item(K_PLAY, 32'hFFFF_FFF0));
        for (int k = 1; k <= 6; k++) send_item(timed_item(K_TICK, 32'hFFFF_FFF0 + 32'(k * 5)));
        send_item(timed_item(K_STOP, 32'd20));
        send_item(timed_item(K_TICK, 32'd40));
        configure(4'd15, 1'b1, 16'd0);
        send_item(timed_item(K_PLAY, 32'd1000));
        for (int k = 1; k <= 4; k++) send_item(timed_item(K_TICK, 32'd1000 + 32'(k)));
        now_ms = 32'd2000;
        random_run(10);

        configure(4'd3, 1'b1, 16'd65535);
        random_run(10);

        send_idle = 69;
        recv_idle = 31;
        configure(4'd0, 1'b0, 16'd409);
        random_run(5);
        configure(4'd8, 1'b1, 16'd40960);
        random_run(10);

        send_idle = 0;
        recv_idle = 0;
        configure(4'(1 + $urandom_range(7)), 1'b0, 16'($urandom_range(409, 12000)));
        now_ms = 32'hFFFF_FF00;
        random_run(10);
        configure(4'd8, 1'b1, 16'd2048);
        random_run(10);

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
